// File: hw/rtl/nbcs_pkg.sv
// Shared constants, types and handshake structures of the box centre snap block.
package nbcs_pkg;

    localparam int MAX_BOXES    = 256;
    localparam int COORD_BITS   = 12;
    localparam int RADIUS_BITS  = 13;
    localparam int RESET_RADIUS = 100;

    localparam int ADDR_BITS  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_BITS   = $clog2(MAX_BOXES + 1);
    localparam int CTR_BITS   = 2 * COORD_BITS;
    localparam int SQC_BITS   = 2 * COORD_BITS;
    localparam int SQ_BITS    = 2 * COORD_BITS + 1;
    localparam int ROOT_BITS  = (SQ_BITS + 1) / 2;
    localparam int RAD_BITS   = 2 * ROOT_BITS;
    localparam int REM_BITS   = ROOT_BITS + 3;
    localparam int STEP_BITS  = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;
    localparam int THR_BITS   = 2 * RADIUS_BITS;
    localparam int CMP_BITS   = (SQ_BITS > THR_BITS) ? SQ_BITS : THR_BITS;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef struct packed {
        logic accept;
        logic issue;
        logic take;
        logic root_step;
        logic square;
        logic deliver;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic more;
        logic busy;
        logic win;
        logic out_free;
    } t_stat;

endpackage

// File: hw/rtl/nbcs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module nbcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [ABITS-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [ABITS-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/nbcs_ctrl.sv
// Controller state machine: sequences accept, table scan, square root and delivery.
module nbcs_ctrl import nbcs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_action,
    output logic       o_in_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ROOT,
        S_SQUARE,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [STEP_BITS-1:0] r_step, n_step;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if ((t_action'(i_action) == ACT_QUERY) && !i_stat.cnt_zero) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.win) begin
                    // A closer centre moves the threshold, so the scan restarts after it.
                    o_cmd.take = 1'b1;
                    n_step     = '0;
                    n_state    = S_ROOT;
                end else begin
                    o_cmd.issue = i_stat.more;
                    if (!i_stat.more && !i_stat.busy) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_step          = r_step + 1'b1;
                if (r_step == STEP_BITS'(ROOT_BITS - 1)) begin
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_SCAN;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.deliver = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// File: hw/rtl/nbcs_dp.sv
// Datapath: centre table, distance pipeline, digit-by-digit square root and result registers.
module nbcs_dp import nbcs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic [1:0]             i_action,
    input  logic [COORD_BITS-1:0]  i_box_left,
    input  logic [COORD_BITS-1:0]  i_box_top,
    input  logic [COORD_BITS-1:0]  i_box_right,
    input  logic [COORD_BITS-1:0]  i_box_bottom,
    input  logic [COORD_BITS-1:0]  i_point_x,
    input  logic [COORD_BITS-1:0]  i_point_y,
    input  logic                   i_cfg_valid,
    input  logic [RADIUS_BITS-1:0] i_cfg_data,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [COORD_BITS-1:0]  o_snap_x,
    output logic [COORD_BITS-1:0]  o_snap_y,
    output logic                   o_found,
    output logic                   o_status
);

    // Configuration and table occupancy.
    logic [RADIUS_BITS-1:0] r_radius;
    logic [CNT_BITS-1:0]    r_count;
    logic                   w_full;

    // Query scan state.
    logic [COORD_BITS-1:0]  r_px, r_py;
    logic [CNT_BITS-1:0]    r_idx;
    logic                   r_s1_v, r_s2_v;
    logic [ADDR_BITS-1:0]   r_s1_idx, r_s2_idx;
    logic [COORD_BITS-1:0]  r_s2_cx, r_s2_cy;
    logic [SQC_BITS-1:0]    r_sqx, r_sqy;
    logic [THR_BITS-1:0]    r_thr;

    // Square root unit.
    logic [RAD_BITS-1:0]    r_rad;
    logic [REM_BITS-1:0]    r_rem;
    logic [ROOT_BITS-1:0]   r_root;

    // Pending result and output register.
    logic [COORD_BITS-1:0]  r_res_x, r_res_y;
    logic                   r_res_found, r_res_status;
    logic                   r_ov;
    logic [COORD_BITS-1:0]  r_o_x, r_o_y;
    logic                   r_o_found, r_o_status;

    // Combinational signals.
    t_action                w_act;
    logic [COORD_BITS:0]    w_sum_x, w_sum_y;
    logic [CTR_BITS-1:0]    w_wdata, w_rdata;
    logic                   w_we;
    logic [COORD_BITS-1:0]  w_cx, w_cy, w_dx, w_dy;
    logic [SQ_BITS-1:0]     w_dist2;
    logic                   w_win;
    logic [REM_BITS-1:0]    w_rem_sh, w_trial;
    logic                   w_ge;
    logic [RADIUS_BITS-1:0] w_root_r;

    assign w_act   = t_action'(i_action);
    assign w_full  = (r_count == CNT_BITS'(MAX_BOXES));
    assign w_sum_x = {1'b0, i_box_left} + {1'b0, i_box_right};
    assign w_sum_y = {1'b0, i_box_top} + {1'b0, i_box_bottom};
    assign w_wdata = {w_sum_y[COORD_BITS:1], w_sum_x[COORD_BITS:1]};
    assign w_we    = i_cmd.accept && (w_act == ACT_ADD) && !w_full;

    nbcs_ram #(
        .WIDTH (CTR_BITS),
        .DEPTH (MAX_BOXES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[ADDR_BITS-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[ADDR_BITS-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_cx    = w_rdata[COORD_BITS-1:0];
    assign w_cy    = w_rdata[CTR_BITS-1:COORD_BITS];
    assign w_dx    = (r_px >= w_cx) ? (r_px - w_cx) : (w_cx - r_px);
    assign w_dy    = (r_py >= w_cy) ? (r_py - w_cy) : (w_cy - r_py);
    assign w_dist2 = SQ_BITS'(r_sqx) + SQ_BITS'(r_sqy);
    // Truncated distance below the best is the same as the squared distance below its square.
    assign w_win   = r_s2_v && (CMP_BITS'(w_dist2) < CMP_BITS'(r_thr));

    assign w_rem_sh = {r_rem[REM_BITS-3:0], r_rad[RAD_BITS-1 -: 2]};
    assign w_trial  = REM_BITS'({r_root, 2'b01});
    assign w_ge     = (w_rem_sh >= w_trial);
    // A new best root is always below the radius, so it fits the radius width.
    assign w_root_r = RADIUS_BITS'(r_root);

    assign o_stat.cnt_zero = (r_count == '0);
    assign o_stat.more     = (r_idx != r_count);
    assign o_stat.busy     = r_s1_v || r_s2_v;
    assign o_stat.win      = w_win;
    assign o_stat.out_free = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_BITS'(RESET_RADIUS);
            r_count  <= '0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_radius <= i_cfg_data;
            end
            if (i_cmd.accept && (w_act == ACT_CLEAR)) begin
                r_count <= '0;
            end else if (w_we) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.take) begin
                r_s1_v <= 1'b0;
                r_s2_v <= 1'b0;
            end else begin
                r_s1_v <= i_cmd.issue;
                r_s2_v <= r_s1_v;
            end
            if (i_cmd.deliver) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px         <= i_point_x;
            r_py         <= i_point_y;
            r_idx        <= '0;
            r_thr        <= THR_BITS'(r_radius) * THR_BITS'(r_radius);
            r_res_found  <= 1'b0;
            r_res_status <= (w_act == ACT_ADD) && w_full;
            if (w_act == ACT_QUERY) begin
                r_res_x <= i_point_x;
                r_res_y <= i_point_y;
            end else begin
                r_res_x <= '0;
                r_res_y <= '0;
            end
        end else if (i_cmd.take) begin
            r_res_x     <= r_s2_cx;
            r_res_y     <= r_s2_cy;
            r_res_found <= 1'b1;
            r_idx       <= CNT_BITS'(r_s2_idx) + 1'b1;
            r_rad       <= RAD_BITS'(w_dist2);
            r_rem       <= '0;
            r_root      <= '0;
        end else if (i_cmd.issue) begin
            r_s1_idx <= r_idx[ADDR_BITS-1:0];
            r_idx    <= r_idx + 1'b1;
        end
        if (i_cmd.root_step) begin
            r_rad <= {r_rad[RAD_BITS-3:0], 2'b00};
            if (w_ge) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[ROOT_BITS-2:0], 1'b0};
            end
        end
        if (i_cmd.square) begin
            r_thr <= THR_BITS'(w_root_r) * THR_BITS'(w_root_r);
        end
        r_s2_idx <= r_s1_idx;
        r_s2_cx  <= w_cx;
        r_s2_cy  <= w_cy;
        r_sqx    <= SQC_BITS'(w_dx) * SQC_BITS'(w_dx);
        r_sqy    <= SQC_BITS'(w_dy) * SQC_BITS'(w_dy);
        if (i_cmd.deliver) begin
            r_o_x      <= r_res_x;
            r_o_y      <= r_res_y;
            r_o_found  <= r_res_found;
            r_o_status <= r_res_status;
        end
    end

    assign o_out_valid = r_ov;
    assign o_snap_x    = r_o_x;
    assign o_snap_y    = r_o_y;
    assign o_found     = r_o_found;
    assign o_status    = r_o_status;

endmodule

// File: hw/rtl/nearest_box_center_snap_core.sv
// Nearest box centre snap: the top level joining the controller and the datapath.
//
// Each transaction is a clear, an add or a query and gives one result. A query scans
// the stored centres through a read and distance pipeline at one centre per cycle;
// every time a strictly closer centre is found, the scan pauses for a 13-step square
// root, the threshold squaring and a pipeline refill. A finished result waits in the
// output register while the next transaction is accepted and processed. The snap
// radius may be written at any time the block is idle and takes effect from the next
// query.
module nearest_box_center_snap_core import nbcs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_action,
    input  logic [COORD_BITS-1:0]  i_box_left,
    input  logic [COORD_BITS-1:0]  i_box_top,
    input  logic [COORD_BITS-1:0]  i_box_right,
    input  logic [COORD_BITS-1:0]  i_box_bottom,
    input  logic [COORD_BITS-1:0]  i_point_x,
    input  logic [COORD_BITS-1:0]  i_point_y,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [RADIUS_BITS-1:0] i_cfg_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [COORD_BITS-1:0]  o_snap_x,
    output logic [COORD_BITS-1:0]  o_snap_y,
    output logic                   o_found,
    output logic                   o_status
);

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    nbcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    nbcs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_action     (i_action),
        .i_box_left   (i_box_left),
        .i_box_top    (i_box_top),
        .i_box_right  (i_box_right),
        .i_box_bottom (i_box_bottom),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_snap_x     (o_snap_x),
        .o_snap_y     (o_snap_y),
        .o_found      (o_found),
        .o_status     (o_status)
    );

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the nearest box centre snap block.
`timescale 1ns / 1ps

module testbench;
    import nbcs_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int FULL_PHASE    = 4;
    localparam int HOLD_PHASE    = 3;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;
    localparam logic [RADIUS_BITS-1:0] RADIUS_AT_RESET = 13'd100;
    localparam logic [RADIUS_BITS-1:0] RADIUS_MAX      = 13'd8191;
    localparam logic [COORD_BITS-1:0]  COORD_MAX       = 12'd4095;
    // A query over a full table is the slowest case; with the sender gaps and receiver
    // stalls, some 1400 transactions stay well below this limit.
    localparam int LIMIT_CYCLES  = 25_000_000;

    typedef struct packed {
        t_action               act;
        logic [COORD_BITS-1:0] left_x;
        logic [COORD_BITS-1:0] top_y;
        logic [COORD_BITS-1:0] right_x;
        logic [COORD_BITS-1:0] bottom_y;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
    } t_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic                  found;
        logic                  status;
    } t_snap;

    typedef struct packed {
        logic                   cfg_en;
        logic [RADIUS_BITS-1:0] cfg_val;
        t_item                  item;
        logic                   typed;
        t_snap                  want;
    } t_row;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    t_item                  in_item   = '0;
    logic                   cfg_valid = 1'b0;
    logic [RADIUS_BITS-1:0] cfg_data  = '0;
    logic                   out_ready = 1'b0;
    logic                   in_ready;
    logic                   cfg_ready;
    logic                   out_valid;
    t_snap                  out_snap;

    // Shadow state of the block.
    logic [COORD_BITS-1:0]  centre_x [MAX_BOXES];
    logic [COORD_BITS-1:0]  centre_y [MAX_BOXES];
    int                     box_count = 0;
    logic [RADIUS_BITS-1:0] snap_radius = RADIUS_AT_RESET;

    t_snap snap_queue [$];
    t_row  dir_rows [$];

    int    errors      = 0;
    int    n_items     = 0;
    int    n_ignored   = 0;
    int    n_queries   = 0;
    int    n_found     = 0;
    int    n_dropped   = 0;
    int    n_radius    = 0;
    int    n_results   = 0;
    int    cycle_count = 0;
    int    burst_left  = 0;
    bit    hold_req    = 1'b0;
    bit    hold_active = 1'b0;
    t_snap oldest;

    nearest_box_center_snap_core i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_action     (in_item.act),
        .i_box_left   (in_item.left_x),
        .i_box_top    (in_item.top_y),
        .i_box_right  (in_item.right_x),
        .i_box_bottom (in_item.bottom_y),
        .i_point_x    (in_item.px),
        .i_point_y    (in_item.py),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_snap_x     (out_snap.sx),
        .o_snap_y     (out_snap.sy),
        .o_found      (out_snap.found),
        .o_status     (out_snap.status)
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    // Floor of the square root, one result bit per pair of operand bits.
    function automatic logic [RADIUS_BITS-1:0] int_sqrt(input logic [2*COORD_BITS:0] v);
        logic [2*COORD_BITS+1:0] rest;
        logic [2*COORD_BITS+1:0] root;
        logic [2*COORD_BITS+1:0] probe;
        rest  = {1'b0, v};
        root  = '0;
        probe = 26'd1 << (2 * COORD_BITS);
        while (probe > rest)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rest >= root + probe) begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root[RADIUS_BITS-1:0];
    endfunction

    task automatic predict_snap(input t_item it, output t_snap r);
        logic [COORD_BITS:0]    sum_x;
        logic [COORD_BITS:0]    sum_y;
        logic [COORD_BITS-1:0]  dx;
        logic [COORD_BITS-1:0]  dy;
        logic [RADIUS_BITS-1:0] best;
        logic [RADIUS_BITS-1:0] d_root;
        int                     i;
        r = '0;
        case (it.act)
            ACT_CLEAR: begin
                box_count = 0;
            end
            ACT_ADD: begin
                if (box_count >= MAX_BOXES) begin
                    r.status = 1'b1;
                end else begin
                    sum_x = {1'b0, it.left_x} + {1'b0, it.right_x};
                    sum_y = {1'b0, it.top_y} + {1'b0, it.bottom_y};
                    centre_x[box_count] = sum_x[COORD_BITS:1];
                    centre_y[box_count] = sum_y[COORD_BITS:1];
                    box_count++;
                end
            end
            ACT_QUERY: begin
                r.sx = it.px;
                r.sy = it.py;
                best = snap_radius;
                for (i = 0; i < box_count; i++) begin
                    dx = (it.px >= centre_x[i]) ? it.px - centre_x[i] : centre_x[i] - it.px;
                    dy = (it.py >= centre_y[i]) ? it.py - centre_y[i] : centre_y[i] - it.py;
                    d_root = int_sqrt(SQ_BITS'(dx) * SQ_BITS'(dx) + SQ_BITS'(dy) * SQ_BITS'(dy));
                    // Strictly below, so the first of equally close centres wins.
                    if (d_root < best) begin
                        best    = d_root;
                        r.sx    = centre_x[i];
                        r.sy    = centre_y[i];
                        r.found = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    function automatic t_item random_fields();
        t_item it;
        it.act      = t_action'(2'($urandom_range(0, 3)));
        it.left_x   = COORD_BITS'($urandom_range(0, COORD_MAX));
        it.top_y    = COORD_BITS'($urandom_range(0, COORD_MAX));
        it.right_x  = COORD_BITS'($urandom_range(0, COORD_MAX));
        it.bottom_y = COORD_BITS'($urandom_range(0, COORD_MAX));
        it.px       = COORD_BITS'($urandom_range(0, COORD_MAX));
        it.py       = COORD_BITS'($urandom_range(0, COORD_MAX));
        return it;
    endfunction

    function automatic logic [COORD_BITS-1:0] near_coord(input logic [COORD_BITS-1:0] c,
                                                         input int spread);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        else if (v > int'(COORD_MAX))
            v = int'(COORD_MAX);
        return v[COORD_BITS-1:0];
    endfunction

    task automatic table_row(input logic cfg_en, input logic [RADIUS_BITS-1:0] cfg_val,
                             input t_action act,
                             input logic [COORD_BITS-1:0] lx, ty, rx, by, px, py,
                             input logic typed,
                             input logic [COORD_BITS-1:0] wx, wy, input logic wf, ws);
        t_row row;
        row.cfg_en        = cfg_en;
        row.cfg_val       = cfg_val;
        row.item.act      = act;
        row.item.left_x   = lx;
        row.item.top_y    = ty;
        row.item.right_x  = rx;
        row.item.bottom_y = by;
        row.item.px       = px;
        row.item.py       = py;
        row.typed         = typed;
        row.want.sx       = wx;
        row.want.sy       = wy;
        row.want.found    = wf;
        row.want.status   = ws;
        dir_rows = {dir_rows, row};
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(input t_item it, input logic typed, input t_snap want);
        int    gap;
        t_snap predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        predict_snap(it, predicted);
        if (typed)
            snap_queue = {snap_queue, want};
        else
            snap_queue = {snap_queue, predicted};
        if (it.act == ACT_NONE)
            n_ignored++;
        else
            n_items++;
        if (it.act == ACT_QUERY)
            n_queries++;
        n_found   += int'(predicted.found);
        n_dropped += int'(predicted.status);
        @(negedge clk);
    endtask

    // Radius writes only happen once every result has been taken.
    task automatic write_radius(input logic [RADIUS_BITS-1:0] value);
        in_valid <= 1'b0;
        while (snap_queue.size() != 0)
            @(negedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        snap_radius = value;
        n_radius++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: stretches of differing stall behaviour, overridden by the hold-off.
    initial begin
        int style;
        int stretch;
        forever begin
            style   = $urandom_range(0, 3);
            stretch = $urandom_range(10, 120);
            repeat (stretch) begin
                @(negedge clk);
                if (hold_active) begin
                    out_ready <= 1'b0;
                end else begin
                    case (style)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= 1'($urandom_range(0, 1));
                        2:       out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    // One long hold-off of the receiver, so that the block backs up and stalls its input.
    initial begin
        while (!hold_req)
            @(posedge clk);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            n_results++;
            if (snap_queue.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("Unexpected result: x=%0d y=%0d found=%b status=%b",
                             out_snap.sx, out_snap.sy, out_snap.found, out_snap.status);
            end else begin
                oldest = snap_queue.pop_front();
                if (out_snap.sx !== oldest.sx || out_snap.sy !== oldest.sy ||
                    out_snap.found !== oldest.found || out_snap.status !== oldest.status) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("Result %0d mismatch: expected x=%0d y=%0d found=%b status=%b",
                                 n_results, oldest.sx, oldest.sy, oldest.found, oldest.status);
                        $display("    got x=%0d y=%0d found=%b status=%b",
                                 out_snap.sx, out_snap.sy, out_snap.found, out_snap.status);
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, snap_queue.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        t_snap                  no_snap;
        t_item                  it;
        t_row                   row;
        logic [RADIUS_BITS-1:0] radius_pick;
        int                     directed_items;
        int                     phase;
        int                     spread;
        int                     idx;
        int                     waited;
        no_snap = '0;

        // The radius is still at its reset value for the first rows.
        table_row(0, 0, ACT_QUERY, 0, 0, 0, 0, 4095, 0, 1, 4095, 0, 0, 0);
        table_row(0, 0, ACT_NONE, 4095, 4095, 4095, 4095, 4095, 4095, 1, 0, 0, 0, 0);
        table_row(0, 0, ACT_ADD, 0, 0, 0, 0, 4095, 4095, 1, 0, 0, 0, 0);
        table_row(0, 0, ACT_ADD, 4095, 4095, 4095, 4095, 0, 0, 1, 0, 0, 0, 0);
        table_row(0, 0, ACT_ADD, 4095, 4095, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        table_row(0, 0, ACT_ADD, 10, 20, 31, 41, 0, 0, 1, 0, 0, 0, 0);
        table_row(0, 0, ACT_QUERY, 4095, 4095, 4095, 4095, 0, 0, 1, 0, 0, 1, 0);
        table_row(0, 0, ACT_QUERY, 0, 0, 0, 0, 4095, 4095, 1, 4095, 4095, 1, 0);
        table_row(0, 0, ACT_QUERY, 0, 0, 0, 0, 25, 35, 0, 0, 0, 0, 0);
        table_row(0, 0, ACT_QUERY, 0, 0, 0, 0, 2000, 2000, 0, 0, 0, 0, 0);
        table_row(0, 0, ACT_QUERY, 0, 0, 0, 0, 1000, 3000, 0, 0, 0, 0, 0);
        table_row(0, 0, ACT_ADD, 100, 100, 100, 100, 0, 0, 1, 0, 0, 0, 0);
        table_row(0, 0, ACT_ADD, 120, 100, 121, 101, 0, 0, 1, 0, 0, 0, 0);
        // Two centres equally close: the earlier one must win.
        table_row(0, 0, ACT_QUERY, 0, 0, 0, 0, 110, 100, 0, 0, 0, 0, 0);
        table_row(0, 0, ACT_CLEAR, 4095, 4095, 4095, 4095, 4095, 4095, 1, 0, 0, 0, 0);
        table_row(0, 0, ACT_QUERY, 0, 0, 0, 0, 5, 5, 1, 5, 5, 0, 0);
        // A distance equal to the radius does not snap.
        table_row(1, 5, ACT_CLEAR, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        table_row(0, 0, ACT_ADD, 0, 0, 1, 1, 0, 0, 1, 0, 0, 0, 0);
        table_row(0, 0, ACT_QUERY, 0, 0, 0, 0, 3, 4, 1, 3, 4, 0, 0);
        table_row(0, 0, ACT_QUERY, 0, 0, 0, 0, 3, 3, 0, 0, 0, 0, 0);
        table_row(1, 0, ACT_QUERY, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        table_row(1, RADIUS_MAX, ACT_QUERY, 0, 0, 0, 0, 4095, 4095, 0, 0, 0, 0, 0);
        table_row(0, 0, ACT_NONE, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        table_row(0, 0, ACT_ADD, 12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'hAAA, 12'h555,
                  0, 0, 0, 0, 0);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.cfg_en)
                write_radius(row.cfg_val);
            send_item(row.item, row.typed, row.want);
        end
        directed_items = n_items;

        phase = 0;
        while (n_items - directed_items < RANDOM_ITEMS) begin
            phase++;
            case ($urandom_range(0, 7))
                0:       radius_pick = '0;
                1:       radius_pick = RADIUS_MAX;
                2:       radius_pick = RADIUS_BITS'($urandom_range(0, RADIUS_MAX));
                default: radius_pick = RADIUS_BITS'($urandom_range(1, 400));
            endcase
            if (phase == FULL_PHASE)
                radius_pick = RADIUS_MAX;
            write_radius(radius_pick);
            spread = (radius_pick < 400) ? int'(radius_pick) + 20 : 300;
            if (phase == HOLD_PHASE)
                hold_req = 1'b1;

            if (phase == FULL_PHASE) begin
                // Fill the table to the brim, then keep adding so the extra adds are dropped.
                it = random_fields();
                it.act = ACT_CLEAR;
                send_item(it, 1'b0, no_snap);
                repeat (MAX_BOXES + $urandom_range(2, 5)) begin
                    it = random_fields();
                    it.act = ACT_ADD;
                    send_item(it, 1'b0, no_snap);
                end
                repeat (6) begin
                    it = random_fields();
                    it.act = ACT_QUERY;
                    send_item(it, 1'b0, no_snap);
                end
            end else if (phase % 5 == 0) begin
                repeat ($urandom_range(10, 30)) begin
                    it = random_fields();
                    send_item(it, 1'b0, no_snap);
                end
            end else begin
                it = random_fields();
                it.act = ACT_CLEAR;
                send_item(it, 1'b0, no_snap);
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 12)) begin
                    it = random_fields();
                    it.act = ACT_ADD;
                    send_item(it, 1'b0, no_snap);
                end
                repeat ($urandom_range(3, 15)) begin
                    it = random_fields();
                    if ($urandom_range(0, 7) == 0) begin
                        it.act = ACT_ADD;
                    end else begin
                        it.act = ACT_QUERY;
                        // Most queries land close to a stored centre so that snaps happen.
                        if (box_count > 0 && $urandom_range(0, 3) != 0) begin
                            idx   = $urandom_range(0, box_count - 1);
                            it.px = near_coord(centre_x[idx], spread);
                            it.py = near_coord(centre_y[idx], spread);
                        end
                    end
                    send_item(it, 1'b0, no_snap);
                end
            end
        end

        in_valid <= 1'b0;
        waited = 0;
        while (snap_queue.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        if (snap_queue.size() != 0) begin
            errors++;
            $display("%0d expected results never arrived", snap_queue.size());
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Ran %0d transactions plus %0d unused action codes over %0d radius settings.",
                 n_items, n_ignored, n_radius);
        $display("Queries: %0d, snapped: %0d, adds dropped on a full table: %0d, mismatches: %0d.",
                 n_queries, n_found, n_dropped, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
